// File: design/cp3d_pkg.sv
`timescale 1ns / 1ps

package cp3d_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH  = 3'd0,
        REG_IN_HEIGHT = 3'd1,
        REG_IN_DEPTH  = 3'd2,
        REG_PAD_X     = 3'd3,
        REG_PAD_Y     = 3'd4,
        REG_PAD_Z     = 3'd5,
        REG_PAD_VALUE = 3'd6
    } cfg_reg_t;

    // Pad-after half of a pad register starts here
    localparam int PAD_AFTER_LSB = 16;

    // Position flags of one output element
    typedef struct packed {
        logic last_col;
        logic tensor_last;
    } walk_flags_t;

    // Output sideband bit positions
    localparam int USER_CONSUMED = 0;
    localparam int USER_IS_PAD   = 1;
    localparam int USER_ROW_END  = 2;
    localparam int USER_W        = 3;

endpackage

// File: design/cp3d_cfg.sv
`timescale 1ns / 1ps

module cp3d_cfg
    import cp3d_pkg::*;
#(
    parameter int ELEM_BITS = 32,
    parameter int DIM_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic [DIM_BITS-1:0]   before_x,
    output logic [DIM_BITS-1:0]   before_y,
    output logic [DIM_BITS-1:0]   before_z,
    output logic [DIM_BITS-1:0]   size_x,
    output logic [DIM_BITS-1:0]   size_y,
    output logic [DIM_BITS-1:0]   size_z,
    output logic [DIM_BITS+1:0]   ext_x,
    output logic [DIM_BITS+1:0]   ext_y,
    output logic [DIM_BITS+1:0]   ext_z,
    output logic [ELEM_BITS-1:0]  fill_value
);

    localparam int CW = DIM_BITS + 2;

    logic [DIM_BITS-1:0]  width_reg;
    logic [DIM_BITS-1:0]  height_reg;
    logic [DIM_BITS-1:0]  depth_reg;
    logic [DIM_BITS-1:0]  bx_reg;
    logic [DIM_BITS-1:0]  ax_reg;
    logic [DIM_BITS-1:0]  by_reg;
    logic [DIM_BITS-1:0]  ay_reg;
    logic [DIM_BITS-1:0]  bz_reg;
    logic [DIM_BITS-1:0]  az_reg;
    logic [ELEM_BITS-1:0] value_reg;

    // Write one register; bits above the used width are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_BITS'(1);
            height_reg <= DIM_BITS'(1);
            depth_reg  <= DIM_BITS'(1);
            bx_reg     <= '0;
            ax_reg     <= '0;
            by_reg     <= '0;
            ay_reg     <= '0;
            bz_reg     <= '0;
            az_reg     <= '0;
            value_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IN_WIDTH:  width_reg  <= cfg_wdata[DIM_BITS-1:0];
                REG_IN_HEIGHT: height_reg <= cfg_wdata[DIM_BITS-1:0];
                REG_IN_DEPTH:  depth_reg  <= cfg_wdata[DIM_BITS-1:0];
                REG_PAD_X:
                begin
                    bx_reg <= cfg_wdata[DIM_BITS-1:0];
                    ax_reg <= cfg_wdata[PAD_AFTER_LSB +: DIM_BITS];
                end
                REG_PAD_Y:
                begin
                    by_reg <= cfg_wdata[DIM_BITS-1:0];
                    ay_reg <= cfg_wdata[PAD_AFTER_LSB +: DIM_BITS];
                end
                REG_PAD_Z:
                begin
                    bz_reg <= cfg_wdata[DIM_BITS-1:0];
                    az_reg <= cfg_wdata[PAD_AFTER_LSB +: DIM_BITS];
                end
                REG_PAD_VALUE: value_reg <= cfg_wdata[ELEM_BITS-1:0];
                default: ;
            endcase
        end
    end

    // A size of zero counts as one
    assign size_x = (width_reg  == '0) ? DIM_BITS'(1) : width_reg;
    assign size_y = (height_reg == '0) ? DIM_BITS'(1) : height_reg;
    assign size_z = (depth_reg  == '0) ? DIM_BITS'(1) : depth_reg;

    assign before_x   = bx_reg;
    assign before_y   = by_reg;
    assign before_z   = bz_reg;
    assign fill_value = value_reg;

    // Padded extent along each axis
    assign ext_x = CW'(bx_reg) + CW'(size_x) + CW'(ax_reg);
    assign ext_y = CW'(by_reg) + CW'(size_y) + CW'(ay_reg);
    assign ext_z = CW'(bz_reg) + CW'(size_z) + CW'(az_reg);

endmodule

// File: design/cp3d_walk.sv
`timescale 1ns / 1ps

module cp3d_walk
    import cp3d_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [DIM_BITS+1:0] ext_x,
    input  logic [DIM_BITS+1:0] ext_y,
    input  logic [DIM_BITS+1:0] ext_z,
    output logic [DIM_BITS+1:0] col,
    output logic [DIM_BITS+1:0] row,
    output logic [DIM_BITS+1:0] plane,
    output walk_flags_t         flags
);

    localparam int CW = DIM_BITS + 2;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] row_reg;
    logic [CW-1:0] plane_reg;
    logic [CW-1:0] col_next;
    logic [CW-1:0] row_next;
    logic [CW-1:0] plane_next;
    logic [CW:0]   col_inc;
    logic [CW:0]   row_inc;
    logic [CW:0]   plane_inc;
    logic          last_col;
    logic          last_row;
    logic          last_plane;

    // Last-position test; a counter past the extent also counts as last
    always_comb
    begin
        col_inc    = {1'b0, col_reg} + 1'b1;
        row_inc    = {1'b0, row_reg} + 1'b1;
        plane_inc  = {1'b0, plane_reg} + 1'b1;
        last_col   = col_inc >= {1'b0, ext_x};
        last_row   = row_inc >= {1'b0, ext_y};
        last_plane = plane_inc >= {1'b0, ext_z};
    end

    // Advance in raster order: column, then row, then plane
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        plane_next = plane_reg;
        if (!last_col)
        begin
            col_next = col_inc[CW-1:0];
        end
        else
        begin
            col_next = '0;
            if (!last_row)
            begin
                row_next = row_inc[CW-1:0];
            end
            else
            begin
                row_next   = '0;
                plane_next = last_plane ? '0 : plane_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            plane_reg <= '0;
        end
        else if (advance)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            plane_reg <= plane_next;
        end
    end

    assign col               = col_reg;
    assign row               = row_reg;
    assign plane             = plane_reg;
    assign flags.last_col    = last_col;
    assign flags.tensor_last = last_col && last_row && last_plane;

endmodule

// File: design/cp3d_select.sv
`timescale 1ns / 1ps

module cp3d_select
    import cp3d_pkg::*;
#(
    parameter int ELEM_BITS = 32,
    parameter int DIM_BITS  = 16
) (
    input  logic [DIM_BITS+1:0]  col,
    input  logic [DIM_BITS+1:0]  row,
    input  logic [DIM_BITS+1:0]  plane,
    input  logic [DIM_BITS-1:0]  before_x,
    input  logic [DIM_BITS-1:0]  before_y,
    input  logic [DIM_BITS-1:0]  before_z,
    input  logic [DIM_BITS-1:0]  size_x,
    input  logic [DIM_BITS-1:0]  size_y,
    input  logic [DIM_BITS-1:0]  size_z,
    input  logic [ELEM_BITS-1:0] data,
    input  logic [ELEM_BITS-1:0] fill_value,
    output logic [ELEM_BITS-1:0] value,
    output logic                 in_volume
);

    localparam int CW = DIM_BITS + 2;

    logic [CW-1:0] off_x;
    logic [CW-1:0] off_y;
    logic [CW-1:0] off_z;
    logic          in_x;
    logic          in_y;
    logic          in_z;

    // Inside test per axis: coordinate minus pad-before within the size
    always_comb
    begin
        off_x     = col - CW'(before_x);
        off_y     = row - CW'(before_y);
        off_z     = plane - CW'(before_z);
        in_x      = (col >= CW'(before_x)) && (off_x < CW'(size_x));
        in_y      = (row >= CW'(before_y)) && (off_y < CW'(size_y));
        in_z      = (plane >= CW'(before_z)) && (off_z < CW'(size_z));
        in_volume = in_x && in_y && in_z;
        value     = in_volume ? data : fill_value;
    end

endmodule

// File: design/constant_pad_3d_stream.sv
`timescale 1ns / 1ps

// Constant padding of a 3-D tensor, streamed in raster order (x fastest, then
// y, then z). Each input item offers the next unpadded element and yields
// exactly one output item; tuser says whether the offered element was used
// (consumed) or the pad constant went out instead (is_pad), in which case the
// source must offer the same element again. Throughput is one item per clock
// while the sink does not stall: the column/row/plane counters advance in the
// accept cycle, and the inside test and data select sit between the input
// register and the output register. tlast marks the last element of the
// padded tensor. Configure sizes and pads only while the block is idle; a size
// of zero acts as one.
module constant_pad_3d_stream
    import cp3d_pkg::*;
#(
    parameter int ELEM_BITS = 32,
    parameter int DIM_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration
    input  logic                                cfg_we,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_wdata,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // in_data
    input  logic [((ELEM_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_value
    output logic [((ELEM_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // consumed, is_pad, row_end
    output logic [USER_W-1:0]                   m_axis_tuser,
    // tensor_end
    output logic                                m_axis_tlast
);

    localparam int CW = DIM_BITS + 2;
    localparam int TDATA_W = ((ELEM_BITS + 7) / 8) * 8;

    logic [DIM_BITS-1:0]  before_x;
    logic [DIM_BITS-1:0]  before_y;
    logic [DIM_BITS-1:0]  before_z;
    logic [DIM_BITS-1:0]  size_x;
    logic [DIM_BITS-1:0]  size_y;
    logic [DIM_BITS-1:0]  size_z;
    logic [CW-1:0]        ext_x;
    logic [CW-1:0]        ext_y;
    logic [CW-1:0]        ext_z;
    logic [ELEM_BITS-1:0] fill_value;

    logic [CW-1:0]        col;
    logic [CW-1:0]        row;
    logic [CW-1:0]        plane;
    walk_flags_t          flags;

    logic                 in_fire;
    logic                 s1_load;
    logic                 s2_load;

    logic                 s1_valid_reg;
    logic [ELEM_BITS-1:0] s1_data_reg;
    logic [CW-1:0]        s1_col_reg;
    logic [CW-1:0]        s1_row_reg;
    logic [CW-1:0]        s1_plane_reg;
    walk_flags_t          s1_flags_reg;

    logic [ELEM_BITS-1:0] sel_value;
    logic                 sel_inside;

    logic                 s2_valid_reg;
    logic [ELEM_BITS-1:0] s2_value_reg;
    logic                 s2_inside_reg;
    walk_flags_t          s2_flags_reg;

    cp3d_cfg #(
        .ELEM_BITS (ELEM_BITS),
        .DIM_BITS  (DIM_BITS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .before_x   (before_x),
        .before_y   (before_y),
        .before_z   (before_z),
        .size_x     (size_x),
        .size_y     (size_y),
        .size_z     (size_z),
        .ext_x      (ext_x),
        .ext_y      (ext_y),
        .ext_z      (ext_z),
        .fill_value (fill_value)
    );

    cp3d_walk #(
        .DIM_BITS (DIM_BITS)
    ) u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_fire),
        .ext_x   (ext_x),
        .ext_y   (ext_y),
        .ext_z   (ext_z),
        .col     (col),
        .row     (row),
        .plane   (plane),
        .flags   (flags)
    );

    // Pipeline flow: each stage loads when its successor has room
    assign s2_load       = s1_valid_reg && (!s2_valid_reg || m_axis_tready);
    assign s1_load       = !s1_valid_reg || s2_load;
    assign s_axis_tready = s1_load;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Input register: item plus its output position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg  <= s_axis_tdata[ELEM_BITS-1:0];
            s1_col_reg   <= col;
            s1_row_reg   <= row;
            s1_plane_reg <= plane;
            s1_flags_reg <= flags;
        end
    end

    cp3d_select #(
        .ELEM_BITS (ELEM_BITS),
        .DIM_BITS  (DIM_BITS)
    ) u_select (
        .col        (s1_col_reg),
        .row        (s1_row_reg),
        .plane      (s1_plane_reg),
        .before_x   (before_x),
        .before_y   (before_y),
        .before_z   (before_z),
        .size_x     (size_x),
        .size_y     (size_y),
        .size_z     (size_z),
        .data       (s1_data_reg),
        .fill_value (fill_value),
        .value      (sel_value),
        .in_volume  (sel_inside)
    );

    // Output register: hold while the sink stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_value_reg  <= sel_value;
            s2_inside_reg <= sel_inside;
            s2_flags_reg  <= s1_flags_reg;
        end
    end

    assign m_axis_tvalid                = s2_valid_reg;
    assign m_axis_tdata                 = TDATA_W'(s2_value_reg);
    assign m_axis_tuser[USER_CONSUMED]  = s2_inside_reg;
    assign m_axis_tuser[USER_IS_PAD]    = !s2_inside_reg;
    assign m_axis_tuser[USER_ROW_END]   = s2_flags_reg.last_col;
    assign m_axis_tlast                 = s2_flags_reg.tensor_last;

endmodule

// File: design/cp3d_checker.sv
`timescale 1ns / 1ps

module cp3d_checker
    import cp3d_pkg::*;
#(
    parameter int ELEM_BITS = 32
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [((ELEM_BITS+7)/8)*8-1:0] m_axis_tdata,
    input logic [USER_W-1:0]              m_axis_tuser,
    input logic                           m_axis_tlast
);

    // Hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // A position is either padding or consumes the offered element
    a_pad_xor_use: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[USER_IS_PAD] != m_axis_tuser[USER_CONSUMED]))
        else $error("is_pad and consumed disagree");

    // The tensor ends at the end of a row
    a_end_on_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[USER_ROW_END])
        else $error("tensor end away from a row end");

endmodule

bind constant_pad_3d_stream cp3d_checker #(
    .ELEM_BITS (ELEM_BITS)
) u_cp3d_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cp3d_pkg::*;

    localparam int ELEM_W = 32;
    localparam int DIM_W = 16;
    localparam int DATA_W = ((ELEM_W + 7) / 8) * 8;
    localparam int CNT_W = DIM_W + 2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int RANDOM_ITEMS = 950;
    localparam int MAX_REPORTS = 10;
    localparam int MAX_IDLE = 6;

    // One padded output element
    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic              consumed;
        logic              is_pad;
        logic              row_end;
        logic              tensor_end;
    } pad_elem_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic [USER_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    // Register copy used for prediction
    logic [15:0]           size_x = 16'd1;
    logic [15:0]           size_y = 16'd1;
    logic [15:0]           size_z = 16'd1;
    logic [31:0]           pad_x_reg = '0;
    logic [31:0]           pad_y_reg = '0;
    logic [31:0]           pad_z_reg = '0;
    logic [31:0]           pad_const = '0;

    // Output position walked by the predictor
    logic [CNT_W-1:0]      col_cnt = '0;
    logic [CNT_W-1:0]      row_cnt = '0;
    logic [CNT_W-1:0]      plane_cnt = '0;

    pad_elem_t             expected_elems[$];
    int                    mismatch_count = 0;
    bit                    steady = 1'b0;

    always #6 clk = ~clk;

    constant_pad_3d_stream #(
        .ELEM_BITS(ELEM_W),
        .DIM_BITS (DIM_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // Size of zero acts as one
    function automatic int unsigned eff_size(logic [15:0] r);
        logic [DIM_W-1:0] s;
        s = r[DIM_W-1:0];
        return (s == 0) ? 1 : int'(s);
    endfunction

    function automatic int unsigned pad_lo(logic [31:0] r);
        return int'(r[DIM_W-1:0]);
    endfunction

    function automatic int unsigned pad_hi(logic [31:0] r);
        return int'(r[PAD_AFTER_LSB +: DIM_W]);
    endfunction

    function automatic bit axis_in(logic [CNT_W-1:0] pos, int unsigned lo, int unsigned sz);
        int unsigned p;
        p = int'(pos);
        return (p >= lo) && ((p - lo) < sz);
    endfunction

    // Work out the output element for one accepted item and advance the walk
    function automatic pad_elem_t predict_padded_elem(logic [31:0] data);
        int unsigned w, h, d, ow, oh, od;
        bit          in_vol, lc, lr, lp;
        pad_elem_t   e;
        w = eff_size(size_x);
        h = eff_size(size_y);
        d = eff_size(size_z);
        ow = pad_lo(pad_x_reg) + w + pad_hi(pad_x_reg);
        oh = pad_lo(pad_y_reg) + h + pad_hi(pad_y_reg);
        od = pad_lo(pad_z_reg) + d + pad_hi(pad_z_reg);
        in_vol = axis_in(col_cnt, pad_lo(pad_x_reg), w) &&
                 axis_in(row_cnt, pad_lo(pad_y_reg), h) &&
                 axis_in(plane_cnt, pad_lo(pad_z_reg), d);
        lc = (int'(col_cnt) + 1) >= ow;
        lr = (int'(row_cnt) + 1) >= oh;
        lp = (int'(plane_cnt) + 1) >= od;
        e.value = in_vol ? data[ELEM_W-1:0] : pad_const[ELEM_W-1:0];
        e.consumed = in_vol;
        e.is_pad = !in_vol;
        e.row_end = lc;
        e.tensor_end = lc && lr && lp;
        if (!lc) begin
            col_cnt = col_cnt + 1'b1;
        end
        else begin
            col_cnt = '0;
            if (!lr) begin
                row_cnt = row_cnt + 1'b1;
            end
            else begin
                row_cnt = '0;
                if (!lp)
                    plane_cnt = plane_cnt + 1'b1;
                else
                    plane_cnt = '0;
            end
        end
        return e;
    endfunction

    function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        case (idx)
            REG_IN_WIDTH:  size_x = v[15:0];
            REG_IN_HEIGHT: size_y = v[15:0];
            REG_IN_DEPTH:  size_z = v[15:0];
            REG_PAD_X:     pad_x_reg = v;
            REG_PAD_Y:     pad_y_reg = v;
            REG_PAD_Z:     pad_z_reg = v;
            REG_PAD_VALUE: pad_const = v;
            default:       ;
        endcase
    endfunction

    function automatic logic [31:0] pad_pair(int unsigned lo, int unsigned hi);
        return (hi << PAD_AFTER_LSB) | lo;
    endfunction

    // Write all seven registers, one per clock; call only while idle
    task automatic apply_cfg(input logic [31:0] w, input logic [31:0] h,
                             input logic [31:0] d, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz,
                             input logic [31:0] pv);
        cfg_reg_t    order[7];
        logic [31:0] vals[7];
        order = '{REG_IN_WIDTH, REG_IN_HEIGHT, REG_IN_DEPTH, REG_PAD_X,
                  REG_PAD_Y, REG_PAD_Z, REG_PAD_VALUE};
        vals = '{w, h, d, px, py, pz, pv};
        foreach (order[i])
        begin
            cfg_we <= 1'b1;
            cfg_index <= order[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
            shadow_write(order[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Offer one item and wait for the handshake
    task automatic send_item(input logic [31:0] data, output bit used);
        int        gap;
        pad_elem_t e;
        gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        do @(posedge clk); while (!s_axis_tready);
        e = predict_padded_elem(data);
        expected_elems.push_back(e);
        used = e.consumed;
    endtask

    // Send a run of items; when held, each element is held until it is consumed
    task automatic send_run(input int n, input bit held);
        logic [31:0] elem;
        bit          used;
        elem = $urandom();
        repeat (n)
        begin
            send_item(held ? elem : $urandom(), used);
            if (used || !held)
                elem = $urandom();
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_elems.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input pad_elem_t want,
                                   input pad_elem_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%t %s: expected value=%h consumed=%b pad=%b row_end=%b last=%b,",
                     $realtime, what, want.value, want.consumed, want.is_pad,
                     want.row_end, want.tensor_end,
                     " got value=%h consumed=%b pad=%b row_end=%b last=%b",
                     got.value, got.consumed, got.is_pad, got.row_end,
                     got.tensor_end);
    endtask

    // Defaults after reset: 1x1x1 with no padding, every item ends a tensor
    task automatic test_reset_state();
        bit used;
        send_item(32'h0000_0000, used);
        send_item(32'hFFFF_FFFF, used);
        send_item($urandom(), used);
        drain();
    endtask

    // Zero sizes act as one; upper bits of size registers are ignored
    task automatic test_zero_sizes();
        apply_cfg(32'hFFFF_0000, 32'h0, 32'h8000_0000, pad_pair(1, 1), 32'h0, 32'h0,
                  32'hFFFF_FFFF);
        send_run(3, 1'b1);
        drain();
    endtask

    // Shrink the volume mid-tensor so the counters sit beyond the new extent
    task automatic test_resize_midway();
        apply_cfg(32'd3, 32'd2, 32'd1, pad_pair(1, 0), pad_pair(0, 1), 32'h0,
                  32'h5A5A_A5A5);
        send_run(9, 1'b1);
        drain();
        apply_cfg(32'd1, 32'd1, 32'd1, 32'h0, 32'h0, 32'h0, 32'h0);
        send_run(2, 1'b1);
        drain();
    endtask

    // Largest sizes and pads; also write an index that maps to no register
    task automatic test_large_extents();
        apply_cfg(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'h8000_0001);
        send_run(3, 1'b1);
        drain();
        apply_cfg(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h0, 32'h0, 32'h0, 32'h0);
        send_run(1, 1'b1);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_SPARE;
        cfg_wdata <= $urandom();
        @(posedge clk);
        cfg_we <= 1'b0;
        send_run(2, 1'b1);
        drain();
    endtask

    // Random tensors, mostly small, and mostly well-formed element streams
    task automatic test_random_tensors();
        int          sent;
        int          n;
        logic [31:0] w, h, d;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            d = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            if ($urandom_range(0, 15) == 0)
                w = $urandom_range(200, 65535);
            w = w | ($urandom() & 32'hFFFF_0000);
            h = h | ($urandom() & 32'hFFFF_0000);
            d = d | ($urandom() & 32'hFFFF_0000);
            apply_cfg(w, h, d,
                      pad_pair($urandom_range(0, 2), $urandom_range(0, 2)),
                      pad_pair($urandom_range(0, 2), $urandom_range(0, 2)),
                      pad_pair($urandom_range(0, 1), $urandom_range(0, 1)),
                      $urandom());
            steady = ($urandom_range(0, 3) == 0);
            n = $urandom_range(15, 60);
            send_run(n, $urandom_range(0, 4) != 0);
            sent += n;
            drain();
        end
        steady = 1'b0;
    endtask

    // Accept results with random stalls and compare against predictions
    initial
    begin : result_checker
        int        stall;
        pad_elem_t got;
        pad_elem_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got.value = m_axis_tdata[ELEM_W-1:0];
            got.consumed = m_axis_tuser[USER_CONSUMED];
            got.is_pad = m_axis_tuser[USER_IS_PAD];
            got.row_end = m_axis_tuser[USER_ROW_END];
            got.tensor_end = m_axis_tlast;
            if (expected_elems.size() == 0)
            begin
                report_mismatch("unexpected result", '0, got);
            end
            else
            begin
                want = expected_elems.pop_front();
                if (got !== want)
                    report_mismatch("mismatch", want, got);
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_zero_sizes();
        test_resize_midway();
        test_large_extents();
        test_random_tensors();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_elems.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop if the stream hangs
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
